@@ hdl/calendar_date_offset_defines.svh @@
// Assertion macros shared by the calendar date offset checker.
`ifndef CALENDAR_DATE_OFFSET_DEFINES_SVH
`define CALENDAR_DATE_OFFSET_DEFINES_SVH

// Concurrent assertion on a given clock, disabled while the active-low reset is asserted.
`define CDO_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same check on the block's own clock and reset names.
`define CDO_ASSERT(lbl, prop, msg) \
  `CDO_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ hdl/cdo_pkg.sv @@
// Types, constants and calendar helper functions for the calendar date offset block.
package cdo_pkg;

  // Field widths of the held date.
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;

  // Working widths of the signed month and year during a command.
  localparam int MONTH_WORK_W = 14;
  localparam int YEAR_WORK_W  = 16;

  // Year residue modulo the 400-year Gregorian cycle.
  localparam int YMOD_W = 9;

  // Calendar constants.
  localparam int MONTHS_PER_YEAR = 12;
  localparam int LEAP_CYCLE      = 400;
  localparam int CENTURY         = 100;
  localparam int FEB_DAYS        = 28;
  localparam int SHORT_DAYS      = 30;
  localparam int LONG_DAYS       = 31;
  localparam int YEAR_LO         = 1;
  localparam int YEAR_HI         = 9999;

  // Binary steps of the year reduction: 400 << 4 is the largest multiple used, enough for years up to YEAR_HI.
  localparam int MOD_STEPS = 5;
  localparam int MOD_CNT_W = 3;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_SUB  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  // Finished result of one command.
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               range_error;
  } result_t;

  // Leap year test on the year residue modulo 400.
  function automatic logic is_leap(input logic [YMOD_W-1:0] r);
    logic div4;
    logic century;
    div4    = (r[1:0] == 2'b00);
    century = (r == YMOD_W'(CENTURY)) || (r == YMOD_W'(2 * CENTURY)) ||
              (r == YMOD_W'(3 * CENTURY));
    return div4 && !century;
  endfunction

  // Length of a month (1..12) given the leap flag of its year.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m) inside
      4'd2:                     len = DAY_W'(FEB_DAYS) + DAY_W'(leap);
      4'd4, 4'd6, 4'd9, 4'd11:  len = DAY_W'(SHORT_DAYS);
      default:                  len = DAY_W'(LONG_DAYS);
    endcase
    return len;
  endfunction

endpackage

@@ hdl/cdo_cmd_if.sv @@
// Command channel: valid/ready handshake carrying one command beat.
interface cdo_cmd_if #(
  parameter int DAY_OFFSET_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic [DAY_OFFSET_WIDTH-1:0]   day_value;
  logic [11:0]                   month_value;
  logic [13:0]                   year_value;

  modport source (output valid, command, day_value, month_value, year_value,
                  input ready);
  modport sink   (input valid, command, day_value, month_value, year_value,
                  output ready);
endinterface

@@ hdl/cdo_res_if.sv @@
// Result channel: valid/ready handshake carrying the date after each command.
interface cdo_res_if;
  logic        valid;
  logic        ready;
  logic [4:0]  day_out;
  logic [3:0]  month_out;
  logic [13:0] year_out;
  logic        range_error;

  modport source (output valid, day_out, month_out, year_out, range_error,
                  input ready);
  modport sink   (input valid, day_out, month_out, year_out, range_error,
                  output ready);
endinterface

@@ hdl/cdo_core.sv @@
// Date register and sequencer: month wrap, year reduction and a one-month-per-cycle day walk.
module cdo_core #(
  parameter int DAY_OFFSET_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  cdo_pkg::cmd_e                 command_i,
  input  logic [DAY_OFFSET_WIDTH-1:0]   day_value_i,
  input  logic [11:0]                   month_value_i,
  input  logic [13:0]                   year_value_i,
  input  logic                          hold_i,
  output logic                          ready_o,
  output logic                          done_o,
  output cdo_pkg::result_t              result_o
);

  // Signed day working width: room for the offset plus a month's days, and negatives.
  localparam int DW = DAY_OFFSET_WIDTH + 2;
  localparam int MW = cdo_pkg::MONTH_WORK_W;
  localparam int YW = cdo_pkg::YEAR_WORK_W;
  localparam int RW = cdo_pkg::YEAR_W;
  localparam int QW = cdo_pkg::YMOD_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WRAP = 5'b00010,
    S_MOD  = 5'b00100,
    S_WALK = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e                  state_q, state_d;
  cdo_pkg::cmd_e           cmd_q, cmd_d;
  logic                    err_q, err_d;
  logic signed [DW-1:0]    d_q, d_d;
  logic signed [MW-1:0]    m_q, m_d;
  logic signed [YW-1:0]    y_q, y_d;
  logic [RW-1:0]           rem_q, rem_d;
  logic [cdo_pkg::MOD_CNT_W-1:0] k_q, k_d;
  logic [cdo_pkg::DAY_W-1:0]     cur_day_q, cur_day_d;
  logic [cdo_pkg::MONTH_W-1:0]   cur_month_q, cur_month_d;
  logic [cdo_pkg::YEAR_W-1:0]    cur_year_q, cur_year_d;

  // Operands of the command, widened to the working widths.
  logic signed [DW-1:0] dv_ext, cd_ext;
  logic signed [MW-1:0] mv_ext, cm_ext;
  logic signed [YW-1:0] yv_ext, cy_ext;
  logic                 load_ok;

  // Shared walk-step signals.
  logic [cdo_pkg::MONTH_W-1:0] mo, mo_prev;
  logic [QW-1:0]               rem9, rem_prev, rem_next;
  logic [cdo_pkg::DAY_W-1:0]   len_cur, len_prev;
  logic signed [DW-1:0]        len_cur_ext, len_prev_ext;
  logic                        yr_ok, at_jan, at_dec;
  logic [RW-1:0]               mod_sub;
  logic                        commit;

  assign dv_ext = $signed({2'b00, day_value_i});
  assign cd_ext = $signed({{(DW - cdo_pkg::DAY_W){1'b0}}, cur_day_q});
  assign mv_ext = $signed({2'b00, month_value_i});
  assign cm_ext = $signed({{(MW - cdo_pkg::MONTH_W){1'b0}}, cur_month_q});
  assign yv_ext = $signed({2'b00, year_value_i});
  assign cy_ext = $signed({2'b00, cur_year_q});

  // Load checks that do not need the month length.
  assign load_ok = (year_value_i >= 14'(cdo_pkg::YEAR_LO)) &&
                   (year_value_i <= 14'(cdo_pkg::YEAR_HI)) &&
                   (month_value_i >= 12'd1) &&
                   (month_value_i <= 12'(cdo_pkg::MONTHS_PER_YEAR)) &&
                   (day_value_i != '0);

  // Month lengths of the current month and of the previous one.
  assign mo       = m_q[cdo_pkg::MONTH_W-1:0];
  assign rem9     = rem_q[QW-1:0];
  assign at_jan   = (mo == 4'd1);
  assign at_dec   = (mo == 4'(cdo_pkg::MONTHS_PER_YEAR));
  assign mo_prev  = at_jan ? 4'(cdo_pkg::MONTHS_PER_YEAR) : mo - 4'd1;
  assign rem_prev = !at_jan ? rem9 :
                    (rem9 == '0) ? QW'(cdo_pkg::LEAP_CYCLE - 1) : rem9 - QW'(1);
  assign rem_next = (rem9 == QW'(cdo_pkg::LEAP_CYCLE - 1)) ? '0 : rem9 + QW'(1);
  assign len_cur  = cdo_pkg::month_len(mo, cdo_pkg::is_leap(rem9));
  assign len_prev = cdo_pkg::month_len(mo_prev, cdo_pkg::is_leap(rem_prev));
  assign len_cur_ext  = $signed({{(DW - cdo_pkg::DAY_W){1'b0}}, len_cur});
  assign len_prev_ext = $signed({{(DW - cdo_pkg::DAY_W){1'b0}}, len_prev});
  assign yr_ok = (y_q >= YW'(cdo_pkg::YEAR_LO)) && (y_q <= YW'(cdo_pkg::YEAR_HI));

  // One binary step of the year reduction modulo 400.
  assign mod_sub = RW'(cdo_pkg::LEAP_CYCLE) << k_q;

  // A finished command changes the date only when it succeeded and did something.
  assign commit = !err_q && (cmd_q != cdo_pkg::CMD_NOP);

  assign ready_o = (state_q == S_IDLE);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    err_d       = err_q;
    d_d         = d_q;
    m_d         = m_q;
    y_d         = y_q;
    rem_d       = rem_q;
    k_d         = k_q;
    cur_day_d   = cur_day_q;
    cur_month_d = cur_month_q;
    cur_year_d  = cur_year_q;
    done_o      = 1'b0;
    result_o.day         = cur_day_q;
    result_o.month       = cur_month_q;
    result_o.year        = cur_year_q;
    result_o.range_error = err_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d = command_i;
          err_d = 1'b0;
          unique case (command_i)
            cdo_pkg::CMD_LOAD: begin
              d_d   = dv_ext;
              m_d   = mv_ext;
              y_d   = yv_ext;
              rem_d = year_value_i;
              k_d   = cdo_pkg::MOD_CNT_W'(cdo_pkg::MOD_STEPS - 1);
              if (load_ok) begin
                state_d = S_MOD;
              end else begin
                err_d   = 1'b1;
                state_d = S_FIN;
              end
            end
            cdo_pkg::CMD_ADD: begin
              d_d     = cd_ext + dv_ext;
              m_d     = cm_ext + mv_ext;
              y_d     = cy_ext + yv_ext;
              state_d = S_WRAP;
            end
            cdo_pkg::CMD_SUB: begin
              d_d     = cd_ext - dv_ext;
              m_d     = cm_ext - mv_ext;
              y_d     = cy_ext - yv_ext;
              state_d = S_WRAP;
            end
            cdo_pkg::CMD_NOP: begin
              state_d = S_FIN;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      // Fold the month into 1..12, one year per cycle, then check the year.
      S_WRAP: begin
        if (m_q > MW'(cdo_pkg::MONTHS_PER_YEAR)) begin
          m_d = m_q - MW'(cdo_pkg::MONTHS_PER_YEAR);
          y_d = y_q + YW'(1);
        end else if (m_q < MW'(1)) begin
          m_d = m_q + MW'(cdo_pkg::MONTHS_PER_YEAR);
          y_d = y_q - YW'(1);
        end else if (yr_ok) begin
          rem_d   = y_q[RW-1:0];
          k_d     = cdo_pkg::MOD_CNT_W'(cdo_pkg::MOD_STEPS - 1);
          state_d = S_MOD;
        end else begin
          err_d   = 1'b1;
          state_d = S_FIN;
        end
      end

      // Restoring reduction of the year modulo 400, one shifted multiple per cycle.
      S_MOD: begin
        if (rem_q >= mod_sub) begin
          rem_d = rem_q - mod_sub;
        end
        if (k_q == '0) begin
          state_d = S_WALK;
        end else begin
          k_d = k_q - cdo_pkg::MOD_CNT_W'(1);
        end
      end

      // Carry the day across month ends, one month per cycle; a load only checks its day.
      S_WALK: begin
        if (!yr_ok) begin
          err_d   = 1'b1;
          state_d = S_FIN;
        end else if (cmd_q == cdo_pkg::CMD_LOAD) begin
          err_d   = (d_q > len_cur_ext);
          state_d = S_FIN;
        end else if (d_q < DW'(1)) begin
          d_d   = d_q + len_prev_ext;
          m_d   = $signed({{(MW - cdo_pkg::MONTH_W){1'b0}}, mo_prev});
          rem_d = {{(RW - QW){1'b0}}, rem_prev};
          if (at_jan) begin
            y_d = y_q - YW'(1);
          end
        end else if (d_q > len_cur_ext) begin
          d_d = d_q - len_cur_ext;
          if (at_dec) begin
            m_d   = MW'(1);
            y_d   = y_q + YW'(1);
            rem_d = {{(RW - QW){1'b0}}, rem_next};
          end else begin
            m_d = m_q + MW'(1);
          end
        end else begin
          state_d = S_FIN;
        end
      end

      // Hand the result over once the output register is free.
      S_FIN: begin
        if (commit) begin
          result_o.day   = d_q[cdo_pkg::DAY_W-1:0];
          result_o.month = m_q[cdo_pkg::MONTH_W-1:0];
          result_o.year  = y_q[cdo_pkg::YEAR_W-1:0];
        end
        if (!hold_i) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
          if (commit) begin
            cur_day_d   = d_q[cdo_pkg::DAY_W-1:0];
            cur_month_d = m_q[cdo_pkg::MONTH_W-1:0];
            cur_year_d  = y_q[cdo_pkg::YEAR_W-1:0];
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state and the held date.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= cdo_pkg::CMD_NOP;
      err_q       <= 1'b0;
      k_q         <= '0;
      cur_day_q   <= cdo_pkg::DAY_W'(1);
      cur_month_q <= cdo_pkg::MONTH_W'(1);
      cur_year_q  <= cdo_pkg::YEAR_W'(1);
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      err_q       <= err_d;
      k_q         <= k_d;
      cur_day_q   <= cur_day_d;
      cur_month_q <= cur_month_d;
      cur_year_q  <= cur_year_d;
    end
  end

  // Working registers of the walk.
  always_ff @(posedge clk_i) begin
    d_q   <= d_d;
    m_q   <= m_d;
    y_q   <= y_d;
    rem_q <= rem_d;
  end

endmodule

@@ hdl/calendar_date_offset.sv @@
// Top level of the calendar date offset block: handshakes, sequencer and output register.
//
//   Channel  Dir  Beat content
//   cmd_i    in   command, day_value, month_value, year_value
//   res_o    out  day_out, month_out, year_out, range_error
//
// A load runs the year reduction and then checks its day against the month length; the
// unused command or a load that fails its field checks goes straight to the result. Add
// and subtract fold the month sum a year at a time (up to 342), reduce the year, then carry
// the day a month at a time (up to about 2155 months at the default width).
// Reset sets the date to day 1, month 1, year 1; no clearing pass is needed.
// cmd_i.ready is high only while idle; a finished result waits for a free output register.
module calendar_date_offset #(
  parameter int DAY_OFFSET_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdo_cmd_if.sink    cmd_i,
  cdo_res_if.source  res_o
);

  logic             core_ready;
  logic             core_done;
  logic             hold;
  cdo_pkg::result_t core_res;
  cdo_pkg::result_t res_q;
  logic             res_valid_q;

  // The output register is busy while it holds a beat that is not taken this cycle.
  assign hold = res_valid_q && !res_o.ready;

  cdo_core #(
    .DAY_OFFSET_WIDTH(DAY_OFFSET_WIDTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (cmd_i.valid),
    .command_i     (cdo_pkg::cmd_e'(cmd_i.command)),
    .day_value_i   (cmd_i.day_value),
    .month_value_i (cmd_i.month_value),
    .year_value_i  (cmd_i.year_value),
    .hold_i        (hold),
    .ready_o       (core_ready),
    .done_o        (core_done),
    .result_o      (core_res)
  );

  assign cmd_i.ready = core_ready;

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (core_done) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (core_done) begin
      res_q <= core_res;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.day_out     = res_q.day;
  assign res_o.month_out   = res_q.month;
  assign res_o.year_out    = res_q.year;
  assign res_o.range_error = res_q.range_error;

endmodule

@@ hdl/cdo_checker.sv @@
// Port-level assertions for the calendar date offset block, bound to its top level.
`include "calendar_date_offset_defines.svh"

module cdo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [4:0]  day_out_i,
  input logic [3:0]  month_out_i,
  input logic [13:0] year_out_i,
  input logic        range_error_i
);

  logic        in_fire;
  logic        out_wait;
  logic        date_ok;
  logic [23:0] res_payload;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_wait = out_valid_i && !out_ready_i;

  // A date is valid when day, month and year all lie in their ranges.
  assign date_ok = (day_out_i != 5'd0) && (month_out_i != 4'd0) && (month_out_i <= 4'd12) &&
                   (year_out_i != 14'd0) && (year_out_i <= 14'd9999);

  // The whole result payload, for the stall check.
  assign res_payload = {day_out_i, month_out_i, year_out_i, range_error_i};

  // The sequencer leaves idle right after it takes a command beat.
  `CDO_ASSERT(a_busy_after_cmd, in_fire |=> !in_ready_i, "command taken while still busy")

  // Every result shows a date whose day, month and year lie in their ranges.
  `CDO_ASSERT(a_date_valid, out_valid_i |-> date_ok, "result date out of range")

  // A stalled result beat keeps its payload.
  `CDO_ASSERT(a_res_hold, out_wait |=> out_valid_i && $stable(res_payload), "stalled result changed")

endmodule

bind calendar_date_offset cdo_checker u_cdo_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (cmd_i.valid),
  .in_ready_i    (cmd_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .day_out_i     (res_o.day_out),
  .month_out_i   (res_o.month_out),
  .year_out_i    (res_o.year_out),
  .range_error_i (res_o.range_error)
);
